/* hw/rtl/rgbe_pkg.sv */
// ----------------------------------------------------------------------------
// rgbe_pkg: shared types and constants
// Request and response payloads, status codes, phase codes and the
// controller/datapath command struct for the RGBE run-length scanline decoder.
// ----------------------------------------------------------------------------
package rgbe_pkg;

    localparam logic [2:0] ST_TAKEN   = 3'd0;
    localparam logic [2:0] ST_ROW     = 3'd1;
    localparam logic [2:0] ST_PIXEL   = 3'd2;
    localparam logic [2:0] ST_DONE    = 3'd3;
    localparam logic [2:0] ST_CORRUPT = 3'd4;
    localparam logic [2:0] ST_REFUSED = 3'd5;
    localparam logic [2:0] ST_EMPTY   = 3'd6;

    localparam logic [2:0] PH_HEAD  = 3'd0;
    localparam logic [2:0] PH_FLAT  = 3'd1;
    localparam logic [2:0] PH_COUNT = 3'd2;
    localparam logic [2:0] PH_VALUE = 3'd3;
    localparam logic [2:0] PH_LIT   = 3'd4;
    localparam logic [2:0] PH_READY = 3'd5;
    localparam logic [2:0] PH_ERR   = 3'd6;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [0:0] REG_WIDTH  = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic       command;
        logic [7:0] byte_value;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] red_bits;
        logic [31:0] green_bits;
        logic [31:0] blue_bits;
        logic [11:0] pixel_column;
        logic [15:0] row_number;
        logic        last_of_row;
    } t_out;

    // Controller to datapath.
    typedef struct packed {
        logic       wr_en;     // write one store entry
        logic       rd_en;     // read one store entry
        logic [1:0] rd_plane;  // plane of the read
        logic       rd_save;   // latch last read data into plane register
        logic [1:0] save_plane;
        logic       convert;   // convert latched pixel into floats
    } t_cmd;

    // Exact conversion of m * 2^(e-136) into an IEEE single.
    function automatic logic [31:0] rgbe_channel(input logic [7:0] m, input logic [7:0] e);
        logic [2:0]  k;
        logic [9:0]  ex;
        logic [31:0] res;
        k = 3'd0;
        for (int i = 1; i < 8; i++) begin
            if (m[i]) k = 3'(i);
        end
        ex = 10'({7'd0, k}) + 10'({2'd0, e}) - 10'd9;
        if (e == 8'd0 || m == 8'd0) begin
            res = 32'd0;
        end else if (!ex[9] && ex != 10'd0) begin
            res = {1'b0, ex[7:0], 23'({m, 15'd0} << (4'd8 - 4'(k)))};
        end else begin
            res = 32'({24'd0, m} << (e + 8'd13));
        end
        return res;
    endfunction

endpackage

/* hw/rtl/rgbe_datapath.sv */
// ----------------------------------------------------------------------------
// rgbe_datapath: line store and pixel conversion
// Holds the line store memory, the fetched pixel planes and the float
// conversion of one pixel.
// ----------------------------------------------------------------------------
module rgbe_datapath
    import rgbe_pkg::*;
#(
    parameter int AW = 14
) (
    input  logic          i_clk,
    input  t_cmd          i_cmd,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data,
    output logic [31:0]   o_red,
    output logic [31:0]   o_green,
    output logic [31:0]   o_blue
);

    logic [7:0] r_mem [2**AW];
    logic [7:0] r_rd;
    logic [7:0] r_pl [3];

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) r_mem[i_wr_addr] <= i_wr_data;
        if (i_cmd.rd_en) r_rd <= r_mem[i_rd_addr];
        if (i_cmd.rd_save && i_cmd.save_plane != 2'd3) r_pl[i_cmd.save_plane] <= r_rd;
        if (i_cmd.convert) begin
            o_red   <= rgbe_channel(r_pl[0], r_rd);
            o_green <= rgbe_channel(r_pl[1], r_rd);
            o_blue  <= rgbe_channel(r_pl[2], r_rd);
        end
    end

    assign o_rd_data = r_rd;

endmodule

/* hw/rtl/rgbe_ctrl.sv */
// ----------------------------------------------------------------------------
// rgbe_ctrl: decoder controller
// Parses row heads, counts and runs, sequences store accesses and issues
// one response per request.
// ----------------------------------------------------------------------------
module rgbe_ctrl
    import rgbe_pkg::*;
#(
    parameter int MAX_WIDTH = 4096,
    parameter int AW = 14
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  t_in           i_req,
    input  logic [12:0]   i_width,
    input  logic [15:0]   i_height,
    output t_cmd          o_cmd,
    output logic [AW-1:0] o_wr_addr,
    output logic [7:0]    o_wr_data,
    output logic [AW-1:0] o_rd_addr,
    input  logic [7:0]    i_rd_data,
    input  logic [31:0]   i_red,
    input  logic [31:0]   i_green,
    input  logic [31:0]   i_blue,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output t_out          o_rsp
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RUN  = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CONV = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    localparam logic [15:0] WMAX = 16'(MAX_WIDTH);

    logic [2:0]  r_st, n_st;
    logic [2:0]  r_ph, n_ph;
    logic [1:0]  r_pi, n_pi;
    logic [15:0] r_cc, n_cc;
    logic [7:0]  r_bl, n_bl;
    logic        r_rp, n_rp;
    logic [15:0] r_rc, n_rc;
    logic [15:0] r_ptr, n_ptr;
    logic [7:0]  r_h [4];
    logic [7:0]  r_val, n_val;
    logic [2:0]  r_sub, n_sub;
    logic        r_ovalid, n_ovalid;
    t_out        r_o, n_o;
    logic        r_lastp, n_lastp;
    logic        r_err, n_err;

    logic [15:0] w;
    logic [17:0] w4;
    always_comb begin
        if (i_width == 13'd0) w = 16'd1;
        else if (16'(i_width) > WMAX) w = WMAX;
        else w = 16'(i_width);
        w4 = {w, 2'b00};
    end

    logic accept;
    assign o_req_ready = (r_st == S_IDLE) && (!r_ovalid || i_rsp_ready);
    assign accept = i_req_valid && o_req_ready;
    assign o_rsp_valid = r_ovalid;
    assign o_rsp = r_o;

    logic [AW-1:0] flat_addr, plane_addr;
    assign flat_addr  = AW'(r_cc);
    assign plane_addr = AW'({r_cc, r_pi});

    always_comb begin
        n_st = r_st; n_ph = r_ph; n_pi = r_pi; n_cc = r_cc; n_bl = r_bl;
        n_rp = r_rp; n_rc = r_rc; n_ptr = r_ptr; n_val = r_val; n_sub = r_sub;
        n_err = r_err; n_lastp = r_lastp;
        n_ovalid = r_ovalid && !i_rsp_ready;
        n_o = r_o;
        o_cmd = '0;
        o_wr_addr = flat_addr;
        o_wr_data = i_req.byte_value;
        o_rd_addr = AW'({r_ptr, r_sub[1:0]});
        case (r_st)
            S_IDLE: begin
                if (accept) begin
                    n_ovalid = 1'b1;
                    n_o = '0;
                    n_o.row_number = r_rc;
                    n_o.status = ST_TAKEN;
                    if (r_err) begin
                        n_o.status = ST_CORRUPT;
                    end else if (i_req.command == CMD_PUSH) begin
                        if (r_rc >= i_height) n_o.status = ST_DONE;
                        else if (r_ph == PH_READY) n_o.status = ST_REFUSED;
                        else begin
                            case (r_ph)
                                PH_HEAD, PH_FLAT: begin
                                    o_cmd.wr_en = (r_cc < 16'(4 * MAX_WIDTH));
                                    n_cc = r_cc + 16'd1;
                                    if (r_ph == PH_HEAD && r_cc == 16'd3) begin
                                        if (r_h[0] == 8'd2 && r_h[1] == 8'd2 &&
                                            {r_h[2], i_req.byte_value} == w &&
                                            w >= 16'd8 && !w[15]) begin
                                            n_cc = 16'd0; n_pi = 2'd0; n_ph = PH_COUNT;
                                        end else if (18'(n_cc) >= w4) begin
                                            n_ph = PH_READY; n_ptr = 16'd0;
                                            n_o.status = ST_ROW;
                                        end else n_ph = PH_FLAT;
                                    end else if (r_ph == PH_FLAT && 18'(n_cc) >= w4) begin
                                        n_ph = PH_READY; n_ptr = 16'd0;
                                        n_o.status = ST_ROW;
                                    end
                                end
                                PH_COUNT: begin
                                    if (i_req.byte_value > 8'd128) begin
                                        if (r_cc + 16'(i_req.byte_value - 8'd128) > w) begin
                                            n_err = 1'b1; n_ph = PH_ERR;
                                            n_o.status = ST_CORRUPT;
                                        end else begin
                                            n_bl = i_req.byte_value - 8'd128;
                                            n_rp = 1'b1; n_ph = PH_VALUE;
                                        end
                                    end else if (i_req.byte_value == 8'd0 ||
                                                 r_cc + 16'(i_req.byte_value) > w) begin
                                        n_err = 1'b1; n_ph = PH_ERR;
                                        n_o.status = ST_CORRUPT;
                                    end else begin
                                        n_bl = i_req.byte_value; n_ph = PH_LIT;
                                    end
                                end
                                PH_VALUE: begin
                                    n_ovalid = 1'b0;
                                    n_val = i_req.byte_value;
                                    n_st = S_RUN;
                                end
                                default: begin
                                    o_wr_addr = plane_addr;
                                    o_cmd.wr_en = 1'b1;
                                    n_cc = r_cc + 16'd1;
                                    n_bl = (r_bl != 8'd0) ? r_bl - 8'd1 : 8'd0;
                                    if (n_bl != 8'd0 && n_cc < w) begin
                                        n_o.status = ST_TAKEN;
                                    end else if (n_bl != 8'd0) begin
                                        n_err = 1'b1; n_ph = PH_ERR;
                                        n_o.status = ST_CORRUPT;
                                    end else if (n_cc >= w) begin
                                        n_cc = 16'd0; n_pi = r_pi + 2'd1;
                                        n_ph = PH_COUNT;
                                        if (r_pi == 2'd3) begin
                                            n_ph = PH_READY; n_ptr = 16'd0;
                                            n_o.status = ST_ROW;
                                        end
                                    end else n_ph = PH_COUNT;
                                end
                            endcase
                        end
                    end else if (r_ph == PH_READY) begin
                        n_ovalid = 1'b0;
                        n_sub = 3'd0;
                        n_st = S_RD;
                    end else if (r_rc >= i_height) n_o.status = ST_DONE;
                    else n_o.status = ST_EMPTY;
                end
            end
            S_RUN: begin
                o_wr_addr = plane_addr;
                o_wr_data = r_val;
                if (r_bl != 8'd0) begin
                    o_cmd.wr_en = 1'b1;
                    n_cc = r_cc + 16'd1;
                    n_bl = r_bl - 8'd1;
                end else begin
                    n_rp = 1'b0;
                    n_ovalid = 1'b1;
                    n_o = '0;
                    n_o.row_number = r_rc;
                    n_o.status = ST_TAKEN;
                    n_ph = PH_COUNT;
                    n_st = S_IDLE;
                    if (r_cc >= w) begin
                        n_cc = 16'd0; n_pi = r_pi + 2'd1;
                        if (r_pi == 2'd3) begin
                            n_ph = PH_READY; n_ptr = 16'd0;
                            n_o.status = ST_ROW;
                        end
                    end
                end
            end
            S_RD: begin
                // Fetch planes 0..3; each read lands in the cycle after it is issued.
                o_cmd.rd_en = (r_sub != 3'd4);
                o_cmd.rd_save = (r_sub != 3'd0);
                o_cmd.save_plane = 2'(r_sub - 3'd1);
                n_sub = r_sub + 3'd1;
                if (r_sub == 3'd4) n_st = S_CONV;
            end
            S_CONV: begin
                o_cmd.convert = 1'b1;
                n_st = S_OUT;
            end
            default: begin
                n_ovalid = 1'b1;
                n_o = '0;
                n_o.status = ST_PIXEL;
                n_o.red_bits = i_red;
                n_o.green_bits = i_green;
                n_o.blue_bits = i_blue;
                n_o.pixel_column = r_ptr[11:0];
                n_o.row_number = r_rc;
                n_st = S_IDLE;
                if (r_ptr + 16'd1 >= w) begin
                    n_o.last_of_row = 1'b1;
                    n_ptr = 16'd0; n_cc = 16'd0; n_pi = 2'd0; n_ph = PH_HEAD;
                    if (r_rc != 16'hFFFF) n_rc = r_rc + 16'd1;
                end else n_ptr = r_ptr + 16'd1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_ph <= PH_HEAD; r_pi <= '0; r_cc <= '0; r_bl <= '0;
            r_rp <= 1'b0; r_rc <= '0; r_ptr <= '0; r_sub <= '0; r_ovalid <= 1'b0;
            r_err <= 1'b0; r_lastp <= 1'b0;
        end else begin
            r_st <= n_st; r_ph <= n_ph; r_pi <= n_pi; r_cc <= n_cc; r_bl <= n_bl;
            r_rp <= n_rp; r_rc <= n_rc; r_ptr <= n_ptr; r_sub <= n_sub;
            r_ovalid <= n_ovalid; r_err <= n_err; r_lastp <= n_lastp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o <= n_o;
        r_val <= n_val;
        if (accept && i_req.command == CMD_PUSH && r_ph == PH_HEAD && r_cc < 16'd4)
            r_h[r_cc[1:0]] <= i_req.byte_value;
    end

    logic unused;
    assign unused = ^{i_rd_data, r_lastp, r_rp};

endmodule

/* hw/rtl/rgbe_rle_scanline_decoder_top.sv */
// ----------------------------------------------------------------------------
// rgbe_rle_scanline_decoder_top: RGBE run-length scanline decoder
// Decodes flat and run-length coded RGBE rows into a line store and
// returns pixels as IEEE single floats.
// ----------------------------------------------------------------------------
//  channel   signals                        direction
//  request   i_req_valid/o_req_ready/i_req  in   command and byte
//  response  o_rsp_valid/i_rsp_ready/o_rsp  out  status and pixel
//  config    i_cfg_valid/o_cfg_ready        in   register index and data
//
// A run value is written with one line store write per cycle through the
// single write port. A read steps through the store port (four reads and a
// step for the last read data to land), one conversion and one response
// register load. Reset is synchronous and active low; the store needs no
// clearing. A stalled response holds the next request off until it is taken.
module rgbe_rle_scanline_decoder_top
    import rgbe_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    output logic        o_req_ready,
    input  t_in         i_req,
    output logic        o_rsp_valid,
    input  logic        i_rsp_ready,
    output t_out        o_rsp,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int AW = $clog2(4 * MAX_WIDTH);

    logic [12:0] r_width;
    logic [15:0] r_height;
    t_cmd          cmd;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [7:0]    wr_data, rd_data;
    logic [31:0]   red, green, blue;

    // Configuration registers are always writable.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= 13'd8;
            r_height <= 16'd1;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_WIDTH) r_width <= i_cfg_data[12:0];
            else r_height <= i_cfg_data;
        end
    end

    rgbe_ctrl #(.MAX_WIDTH(MAX_WIDTH), .AW(AW)) u_ctrl (
        .i_clk, .i_rst_n, .i_req_valid, .o_req_ready, .i_req,
        .i_width(r_width), .i_height(r_height), .o_cmd(cmd),
        .o_wr_addr(wr_addr), .o_wr_data(wr_data), .o_rd_addr(rd_addr),
        .i_rd_data(rd_data), .i_red(red), .i_green(green), .i_blue(blue),
        .o_rsp_valid, .i_rsp_ready, .o_rsp
    );

    rgbe_datapath #(.AW(AW)) u_dp (
        .i_clk, .i_cmd(cmd), .i_wr_addr(wr_addr), .i_wr_data(wr_data),
        .i_rd_addr(rd_addr), .o_rd_data(rd_data),
        .o_red(red), .o_green(green), .o_blue(blue)
    );

    // A stalled response must not be replaced.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_rsp))
        else $error("response changed while stalled");

    // No request is taken while a response waits.
    a_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |-> !o_req_ready)
        else $error("request taken over stalled response");

endmodule
